@@ rtl/core/tms_pkg.sv @@
// Package: shared types, constants and index offset table for the triangle subdivider.
package tms_pkg;

  localparam int unsigned IndexBits = 16;
  localparam int unsigned IdxPerTri = 12;
  localparam int unsigned VertsPerTri = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_EMIT
  } tms_state_e;

  typedef struct packed {
    logic start;
  } nrm_ctl_t;

  function automatic logic [2:0] idx_offset(input logic [3:0] k);
    logic [2:0] r;
    case (k)
      4'd0: r = 3'd0;
      4'd1: r = 3'd3;
      4'd2: r = 3'd5;
      4'd3: r = 3'd3;
      4'd4: r = 3'd4;
      4'd5: r = 3'd5;
      4'd6: r = 3'd5;
      4'd7: r = 3'd4;
      4'd8: r = 3'd2;
      4'd9: r = 3'd3;
      4'd10: r = 3'd1;
      4'd11: r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/triangle_midpoint_subdivider.sv @@
// A first or second corner is only stored; a third corner holds s_axis_tready
// low while three midpoint normals go through one shared normalizer in turn,
// then 18 output beats follow, one a cycle while m_axis_tready is high.
// The next triangle's corners are taken only after the last beat is accepted;
// a midpoint whose averaged normal is zero skips the magnitude search.
// Reset: asynchronous active low; corner count and index base clear, held corners do not.
module triangle_midpoint_subdivider (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v
  input  logic [191:0] s_axis_tdata,
  // first_of_mesh
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_pos_x..z, out_norm_x..z, out_tex_u, out_tex_v, index_value
  output logic [191:0] m_axis_tdata,
  // kind
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);
  import tms_pkg::*;

  typedef logic [191:0] vtx_t;

  tms_state_e state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic [IndexBits-1:0] base_q, base_d;
  vtx_t c0_q, c1_q, c2_q;
  logic [1:0] mid_q, mid_d;          // midpoint under normalization
  logic [4:0] out_q, out_d;          // output beat number
  logic signed [15:0] mn_q [3][3];
  vtx_t mids [3];
  vtx_t va, vb;
  logic acc;
  nrm_ctl_t nctl;
  logic ndone;
  logic signed [15:0] rx, ry, rz;

  function automatic vtx_t mid_of(input vtx_t a, input vtx_t b);
    vtx_t m;
    m = '0;
    for (int i = 0; i < 3; i++) begin
      m[32*i +: 32] = 32'((({a[32*i+31], a[32*i +: 32]}) + ({b[32*i+31], b[32*i +: 32]})) >>> 1);
      m[96+16*i +: 16] = 16'(({a[96+16*i+15], a[96+16*i +: 16]}
                              + {b[96+16*i+15], b[96+16*i +: 16]}) >> 1);
    end
    for (int i = 0; i < 2; i++)
      m[144+16*i +: 16] = 16'(({1'b0, a[144+16*i +: 16]} + {1'b0, b[144+16*i +: 16]}) >> 1);
    return m;
  endfunction

  assign mids[0] = mid_of(c0_q, c1_q);
  assign mids[1] = mid_of(c1_q, c2_q);
  assign mids[2] = mid_of(c0_q, c2_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc = s_axis_tvalid && s_axis_tready;

  assign va = mids[mid_q];
  assign vb = va;

  tms_norm u_norm (
    .clk_i, .rst_ni, .ctl_i(nctl),
    .nx_i(vb[111:96]), .ny_i(vb[127:112]), .nz_i(vb[143:128]),
    .done_o(ndone), .rx_o(rx), .ry_o(ry), .rz_o(rz)
  );

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; base_d = base_q; mid_d = mid_q; out_d = out_q;
    nctl = '{start: 1'b0};
    case (state_q)
      ST_IDLE: if (acc) begin
        if (s_axis_tuser) begin
          cnt_d = 2'd1; base_d = '0;
        end else if (cnt_q < 2'd2) begin
          cnt_d = cnt_q + 2'd1;
        end else begin
          cnt_d = 2'd0; state_d = ST_NORM; mid_d = 2'd0; nctl.start = 1'b1;
        end
      end
      ST_NORM: if (ndone) begin
        if (mid_q == 2'd2) begin
          state_d = ST_EMIT; out_d = '0;
        end else begin
          mid_d = mid_q + 2'd1; nctl.start = 1'b1;
        end
      end
      ST_EMIT: if (m_axis_tready) begin
        if (out_q == 5'd17) begin
          state_d = ST_IDLE; base_d = base_q + IndexBits'(VertsPerTri);
        end else begin
          out_d = out_q + 5'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // first_of_mesh with a third-corner count resets and stores as corner 0
  always_ff @(posedge clk_i) begin
    if (acc) begin
      if (s_axis_tuser || cnt_q == 2'd0) c0_q <= s_axis_tdata;
      else if (cnt_q == 2'd1) c1_q <= s_axis_tdata;
      else c2_q <= s_axis_tdata;
    end
    if (state_q == ST_NORM && ndone) begin
      mn_q[mid_q][0] <= rx; mn_q[mid_q][1] <= ry; mn_q[mid_q][2] <= rz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; cnt_q <= '0; base_q <= '0; mid_q <= '0; out_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; base_q <= base_d; mid_q <= mid_d; out_q <= out_d;
    end
  end

  // output beat mux; input padding bits never reach the index field
  logic [IndexBits-1:0] ival;
  logic [1:0] msel;
  assign msel = 2'(out_q - 5'd3);
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tuser = 1'b0;
    ival = base_q + IndexBits'(idx_offset(4'(out_q - 5'd6)));
    if (out_q < 5'd3) begin
      m_axis_tdata[175:0] = (out_q == 5'd0) ? c0_q[175:0] :
                            (out_q == 5'd1) ? c1_q[175:0] : c2_q[175:0];
    end else if (out_q < 5'd6) begin
      m_axis_tdata[175:0] = mids[msel][175:0];
      m_axis_tdata[111:96]  = mn_q[msel][0];
      m_axis_tdata[127:112] = mn_q[msel][1];
      m_axis_tdata[143:128] = mn_q[msel][2];
    end else begin
      m_axis_tuser = 1'b1;
      m_axis_tdata[191:176] = 16'(ival);
    end
  end
  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign m_axis_tlast  = (out_q == 5'd17);

  a_no_in_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input open during output");
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser) else $error("last not on index");
  a_emit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("no return to idle");

endmodule

@@ rtl/core/tms_norm.sv @@
// Normal normalizer: one component at a time, bit-serial search over the result magnitude.
module tms_norm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tms_pkg::nrm_ctl_t   ctl_i,
  input  logic signed [15:0]  nx_i,
  input  logic signed [15:0]  ny_i,
  input  logic signed [15:0]  nz_i,
  output logic                done_o,
  output logic signed [15:0]  rx_o,
  output logic signed [15:0]  ry_o,
  output logic signed [15:0]  rz_o
);
  import tms_pkg::*;

  // phases: 0 squares accumulate, 1 search per component, 2 result per component
  logic [1:0]  comp_q, comp_d;
  logic [3:0]  bit_q, bit_d;
  logic [2:0]  ph_q, ph_d;
  logic        run_q, run_d;
  logic [32:0] s_q, s_d;
  logic [14:0] lo_q, lo_d;
  logic signed [15:0] rx_q, ry_q, rz_q, rx_d, ry_d, rz_d;
  logic [15:0] a_mag;
  logic signed [15:0] a_sel;
  logic [31:0] a_sq;
  logic [14:0] cand;
  logic [15:0] d;
  logic [31:0] dsq;          // product, registered into dsq_q
  logic [31:0] dsq_q;
  logic        chk_q, chk_d;
  logic [63:0] lhs;
  logic [63:0] tgt;

  always_comb begin
    case (comp_q)
      2'd0: a_sel = nx_i;
      2'd1: a_sel = ny_i;
      default: a_sel = nz_i;
    endcase
  end
  assign a_mag = a_sel[15] ? 16'(-a_sel) : a_sel;
  assign a_sq  = a_mag * a_mag;
  assign cand  = lo_q | (15'd1 << bit_q);
  assign d     = {cand, 1'b0} - 16'd1;
  assign dsq   = d * d;
  assign lhs   = 64'(dsq_q) * 64'(s_q);
  assign tgt   = {2'b0, a_sq, 30'd0};

  always_comb begin
    comp_d = comp_q; bit_d = bit_q; ph_d = ph_q; run_d = run_q; s_d = s_q;
    lo_d = lo_q; rx_d = rx_q; ry_d = ry_q; rz_d = rz_q; chk_d = chk_q;
    done_o = 1'b0;
    if (run_q) begin
      case (ph_q)
        3'd0: begin
          s_d = s_q + 33'(a_sq);
          if (comp_q == 2'd2) begin
            ph_d = 3'd1; comp_d = 2'd0; bit_d = 4'd14; lo_d = '0; chk_d = 1'b0;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end
        3'd1: begin
          if (s_q == '0) begin
            rx_d = '0; ry_d = '0; rz_d = '0; run_d = 1'b0; done_o = 1'b1;
          end else if (!chk_q) begin
            chk_d = 1'b1;      // square registered, compare next cycle
          end else begin
            chk_d = 1'b0;
            if (lhs <= tgt) lo_d = cand;
            if (bit_q == 4'd0) begin
              ph_d = 3'd2;
            end else begin
              bit_d = bit_q - 4'd1;
            end
          end
        end
        default: begin
          // magnitude 16384 exactly only for a single-axis vector
          case (comp_q)
            2'd0: rx_d = a_sel[15] ? -16'(lo_q) : 16'(lo_q);
            2'd1: ry_d = a_sel[15] ? -16'(lo_q) : 16'(lo_q);
            default: rz_d = a_sel[15] ? -16'(lo_q) : 16'(lo_q);
          endcase
          if ({1'b0, a_sq} == s_q[32:0]) begin
            case (comp_q)
              2'd0: rx_d = a_sel[15] ? -16'sd16384 : 16'sd16384;
              2'd1: ry_d = a_sel[15] ? -16'sd16384 : 16'sd16384;
              default: rz_d = a_sel[15] ? -16'sd16384 : 16'sd16384;
            endcase
          end
          if (comp_q == 2'd2) begin
            run_d = 1'b0; done_o = 1'b1;
          end else begin
            comp_d = comp_q + 2'd1; ph_d = 3'd1; bit_d = 4'd14; lo_d = '0;
          end
        end
      endcase
    end
    // a start may arrive in the done cycle of the previous vector
    if (ctl_i.start) begin
      run_d = 1'b1; ph_d = 3'd0; comp_d = 2'd0; s_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; ph_q <= '0; comp_q <= '0; bit_q <= '0; chk_q <= 1'b0;
    end else begin
      run_q <= run_d; ph_q <= ph_d; comp_q <= comp_d; bit_q <= bit_d; chk_q <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d; lo_q <= lo_d; dsq_q <= dsq;
    rx_q <= rx_d; ry_q <= ry_d; rz_q <= rz_d;
  end

  // results are complete in the done cycle
  assign rx_o = rx_d;
  assign ry_o = ry_d;
  assign rz_o = rz_d;

endmodule
